/* sv/pbs_pkg.sv */
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types and constants for the polynomial bisection solver: command
// and result words, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam int PBS_MAX_DEGREE = 7;
    localparam int PBS_FRAC_BITS  = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 47;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEGREE    = 2'd0,
        CFG_RANGE     = 2'd1,
        CFG_ATTEMPTS  = 2'd2,
        CFG_TOLERANCE = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_SOLVE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOAD,
        ST_MUL,
        ST_POST,
        ST_ACC,
        ST_RESID,
        ST_CHECK
    } state_t;

    typedef struct packed {
        op_t                operation;
        logic [2:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [63:0] target;
    } in_word_t;

    typedef struct packed {
        logic signed [47:0] root;
        logic [15:0]        attempts_used;
        logic               found;
        logic signed [63:0] residual;
    } result_word_t;

endpackage

/* sv/polynomial_bisection_solver_top.sv */
// ----------------------------------------------------------------------------
// polynomial_bisection_solver_top
// Bisection search for p(x) = target over [-range, +range] with a shared
// 32x32 multiplier stepped by a small sequencer.
// ----------------------------------------------------------------------------
// A load word (operation 0) writes one coefficient and gives no result; busy
// stays low. A solve word raises busy until the result word is shown on result
// for exactly one cycle with done high; the receiver cannot stall, so it must
// take the word in that cycle. Every multiplication runs on one shared 32x32
// unsigned multiplier in four partial-product steps, with an operand-load, a
// scale/saturate and an accumulate step. One evaluation at clamped degree d
// takes 2d+1 multiplications. The coefficient store is cleared at reset.
module polynomial_bisection_solver_top
    import pbs_pkg::*;
#(
    parameter int MAX_DEGREE = PBS_MAX_DEGREE,
    parameter int FRAC_BITS  = PBS_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_word_t              cmd,
    output logic                  done,
    output result_word_t          result,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic signed [63:0] XP_ONE  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63])
            return a[63] ? S64_MIN : S64_MAX;
        return r;
    endfunction

    function automatic logic signed [47:0] midpoint(input logic signed [47:0] a,
                                                    input logic signed [47:0] b);
        logic signed [48:0] s;
        logic signed [48:0] t;
        s = 49'(a) + 49'(b);
        t = s + 49'(s[48]);
        return t[48:1];
    endfunction

    // configuration and coefficient store
    logic [2:0]         degree_reg;
    logic [46:0]        range_reg;
    logic [15:0]        attempts_reg;
    logic [32:0]        tolerance_reg;
    logic signed [31:0] coef_reg [DEPTH];

    // sequencer
    state_t             state_reg;
    state_t             state_next;
    logic [1:0]         step_reg;
    logic               done_reg;

    // search datapath
    logic signed [63:0]  target_reg;
    logic signed [47:0]  x_reg;
    logic signed [47:0]  last_x_reg;
    logic signed [47:0]  high_reg;
    logic signed [47:0]  low_reg;
    logic [15:0]         left_reg;
    logic [15:0]         used_reg;
    logic signed [63:0]  acc_reg;
    logic signed [63:0]  xp_reg;
    logic [IDX_W-1:0]    term_reg;
    logic                phase_xp_reg;
    logic signed [63:0]  resid_reg;
    result_word_t        result_reg;

    // shared multiplier
    logic [63:0]         mag_a_reg;
    logic [63:0]         mag_b_reg;
    logic                neg_reg;
    logic                sh_reg;
    logic [127:0]        prod_reg;
    logic signed [63:0]  mres_reg;

    logic               accept;
    logic               accept_load;
    logic               accept_solve;
    logic [IDX_W-1:0]   deg_use;
    logic               last_term;
    logic signed [63:0] op_a;
    logic signed [63:0] op_b;
    logic [31:0]        a_half;
    logic [31:0]        b_half;
    logic [63:0]        pp;
    logic [127:0]       pp_shifted;
    logic [127:0]       scaled;
    logic signed [63:0] scaled_sat;
    logic [63:0]        resid_mag;
    logic               keep_going;

    always_comb
    begin
        busy         = (state_reg != ST_IDLE);
        accept       = start && !busy;
        accept_load  = accept && (cmd.operation == OP_LOAD);
        accept_solve = accept && (cmd.operation == OP_SOLVE);
        last_term    = !phase_xp_reg && (term_reg == deg_use);
        keep_going   = (resid_mag > 64'(tolerance_reg)) && (left_reg != '0);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept_solve) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_MUL;
            ST_MUL:   if (step_reg == 2'd3) state_next = ST_POST;
            ST_POST:  state_next = ST_ACC;
            ST_ACC:   state_next = last_term ? ST_RESID : ST_LOAD;
            ST_RESID: state_next = ST_CHECK;
            ST_CHECK: state_next = keep_going ? ST_SETUP : ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign deg_use = (32'(degree_reg) > 32'(MAX_DEGREE)) ? IDX_W'(MAX_DEGREE)
                                                         : IDX_W'(degree_reg);

    // operand selection: coefficient term or power update
    assign op_a = phase_xp_reg ? xp_reg : 64'(coef_reg[term_reg]);
    assign op_b = phase_xp_reg ? 64'(x_reg) : xp_reg;

    assign a_half = step_reg[1] ? mag_a_reg[63:32] : mag_a_reg[31:0];
    assign b_half = step_reg[0] ? mag_b_reg[63:32] : mag_b_reg[31:0];
    assign pp     = 64'(a_half) * 64'(b_half);

    always_comb
    begin
        unique case (step_reg)
            2'd0:    pp_shifted = 128'(pp);
            2'd1:    pp_shifted = 128'(pp) << 32;
            2'd2:    pp_shifted = 128'(pp) << 32;
            default: pp_shifted = 128'(pp) << 64;
        endcase
    end

    assign scaled = sh_reg ? (prod_reg >> FRAC_BITS) : prod_reg;

    always_comb
    begin
        if (neg_reg)
        begin
            if (scaled[127:64] != '0 || scaled[63])
                scaled_sat = S64_MIN;
            else
                scaled_sat = -$signed(scaled[63:0]);
        end
        else
        begin
            if (scaled[127:64] != '0 || scaled[63])
                scaled_sat = S64_MAX;
            else
                scaled_sat = $signed(scaled[63:0]);
        end
    end

    assign resid_mag = mag64(resid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            done_reg      <= 1'b0;
            degree_reg    <= 3'd0;
            range_reg     <= 47'h1_0000_0000;
            attempts_reg  <= 16'd64;
            tolerance_reg <= 33'd4295;
            for (int i = 0; i < DEPTH; i++)
                coef_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_reg == ST_MUL) ? step_reg + 2'd1 : 2'd0;
            done_reg  <= (state_reg == ST_CHECK) && !keep_going;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DEGREE:    degree_reg    <= cfg_data[2:0];
                    CFG_RANGE:     range_reg     <= cfg_data[46:0];
                    CFG_ATTEMPTS:  attempts_reg  <= cfg_data[15:0];
                    CFG_TOLERANCE: tolerance_reg <= cfg_data[32:0];
                    default:       ;
                endcase
            end
            if (accept_load && (32'(cmd.coef_index) <= 32'(MAX_DEGREE)))
                coef_reg[IDX_W'(cmd.coef_index)] <= cmd.coef_value;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_solve)
                begin
                    target_reg <= cmd.target;
                    x_reg      <= '0;
                    high_reg   <= $signed({1'b0, range_reg});
                    low_reg    <= -$signed({1'b0, range_reg});
                    left_reg   <= attempts_reg;
                    used_reg   <= '0;
                end
            end
            ST_SETUP:
            begin
                acc_reg      <= '0;
                xp_reg       <= XP_ONE;
                term_reg     <= '0;
                phase_xp_reg <= 1'b0;
            end
            ST_LOAD:
            begin
                mag_a_reg <= mag64(op_a);
                mag_b_reg <= mag64(op_b);
                neg_reg   <= op_a[63] ^ op_b[63];
                sh_reg    <= phase_xp_reg;
                prod_reg  <= '0;
            end
            ST_MUL:
            begin
                prod_reg <= prod_reg + pp_shifted;
            end
            ST_POST:
            begin
                mres_reg <= scaled_sat;
            end
            ST_ACC:
            begin
                if (!phase_xp_reg)
                begin
                    acc_reg      <= sat_add(acc_reg, mres_reg);
                    phase_xp_reg <= 1'b1;
                end
                else
                begin
                    xp_reg       <= mres_reg;
                    term_reg     <= term_reg + IDX_W'(1);
                    phase_xp_reg <= 1'b0;
                end
            end
            ST_RESID:
            begin
                resid_reg  <= sat_sub(acc_reg, target_reg);
                last_x_reg <= x_reg;
                if (acc_reg > target_reg)
                begin
                    high_reg <= x_reg;
                    x_reg    <= midpoint(x_reg, low_reg);
                end
                else if (acc_reg < target_reg)
                begin
                    low_reg <= x_reg;
                    x_reg   <= midpoint(x_reg, high_reg);
                end
                used_reg <= used_reg + 16'd1;
                if (left_reg != '0)
                    left_reg <= left_reg - 16'd1;
            end
            ST_CHECK:
            begin
                if (!keep_going)
                begin
                    result_reg.root          <= last_x_reg;
                    result_reg.attempts_used <= used_reg;
                    result_reg.found         <= (resid_mag < 64'(tolerance_reg));
                    result_reg.residual      <= resid_reg;
                end
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_CHECK))
        else $error("result word without a finished check");

    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_MUL) |-> (step_reg == 2'd0))
        else $error("multiplier step counter left running");

    a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> (term_reg <= deg_use))
        else $error("term index beyond degree");

    a_solve_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.operation == OP_SOLVE) |=> (state_reg == ST_SETUP))
        else $error("solve word did not start an evaluation");

endmodule

/* tb/tb_polynomial_bisection_solver_top.sv */
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_polynomial_bisection_solver_top
// Self-checking bench for the bisection solver. A short table of directed
// loads, solves and register writes opens the run, then twenty phases of
// random traffic follow, each under its own register setting. The bench keeps
// its own copy of the coefficients and registers, predicts every result word
// bit for bit and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_polynomial_bisection_solver_top;
    import pbs_pkg::*;

    localparam int PHASES        = 20;
    localparam int PHASE_WORDS   = 57;
    localparam int QUIET_PHASES  = 3;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 200;
    localparam int PLAN_ROWS     = 30;

    typedef logic signed [63:0] q64_t;

    localparam q64_t Q_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam q64_t Q_MIN = 64'sh8000_0000_0000_0000;
    localparam q64_t Q_ONE = 64'sh0000_0001_0000_0000;

    typedef struct packed {
        logic                  is_write;
        cfg_index_t            reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        in_word_t              word;
        logic                  checked;
        result_word_t          want;
    } plan_row_t;

    localparam in_word_t     NO_WORD   = '0;
    localparam result_word_t NO_RESULT = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    in_word_t              cmd;
    logic                  done;
    result_word_t          result;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [2:0]         cur_degree;
    logic [46:0]        cur_range;
    logic [15:0]        cur_attempts;
    logic [32:0]        cur_tolerance;
    logic signed [31:0] coef_copy [0:PBS_MAX_DEGREE];

    result_word_t pending_results [$];
    int           mismatches   = 0;
    longint       cycle_count  = 0;
    longint       cycle_budget = 50000;
    bit           quiet        = 1'b0;

    plan_row_t plan [0:PLAN_ROWS-1] = '{
        '{1'b0, CFG_DEGREE, '0, '{OP_SOLVE, 3'd0, 32'sd0, 64'sd0},
          1'b1, '{48'sd0, 16'd1, 1'b1, 64'sd0}},
        '{1'b0, CFG_DEGREE, '0, '{OP_SOLVE, 3'd0, 32'sd0, Q_MAX},
          1'b1, '{48'sh0000_ffff_ffff, 16'd64, 1'b0, 64'sh8000_0000_0000_0001}},
        '{1'b0, CFG_DEGREE, '0, '{OP_SOLVE, 3'd0, 32'sd0, Q_MIN},
          1'b1, '{48'shffff_0000_0001, 16'd64, 1'b0, Q_MAX}},
        '{1'b1, CFG_TOLERANCE, 47'd0, NO_WORD, 1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_SOLVE, 3'd0, 32'sd0, 64'sd0},
          1'b1, '{48'sd0, 16'd1, 1'b0, 64'sd0}},
        '{1'b1, CFG_ATTEMPTS, 47'd0, NO_WORD, 1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_SOLVE, 3'd7, 32'shffff_ffff, 64'sd1},
          1'b1, '{48'sd0, 16'd1, 1'b0, 64'shffff_ffff_ffff_ffff}},
        '{1'b0, CFG_DEGREE, '0, '{OP_LOAD, 3'd0, 32'sh7fff_ffff, 64'shffff_ffff_ffff_ffff},
          1'b0, NO_RESULT},
        '{1'b1, CFG_ATTEMPTS, 47'd65535, NO_WORD, 1'b0, NO_RESULT},
        '{1'b1, CFG_TOLERANCE, 47'h1_0000_0000, NO_WORD, 1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_SOLVE, 3'd0, 32'sd0, 64'sh7fff_ffff_0000_0000},
          1'b1, '{48'sd0, 16'd1, 1'b1, 64'sd0}},
        '{1'b0, CFG_DEGREE, '0, '{OP_LOAD, 3'd7, 32'sh8000_0000, 64'sh5555_5555_5555_5555},
          1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_LOAD, 3'd1, 32'sd1, 64'sd0}, 1'b0, NO_RESULT},
        '{1'b1, CFG_DEGREE, 47'd7, NO_WORD, 1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_SOLVE, 3'd2, 32'sd99, 64'sh7fff_ffff_0000_0000},
          1'b1, '{48'sd0, 16'd1, 1'b1, 64'sd0}},
        '{1'b1, CFG_RANGE, 47'h7fff_ffff_ffff, NO_WORD, 1'b0, NO_RESULT},
        '{1'b1, CFG_ATTEMPTS, 47'd40, NO_WORD, 1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_SOLVE, 3'd5, 32'sh1234_5678, 64'sd0}, 1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_SOLVE, 3'd0, 32'sd0, Q_MAX}, 1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_SOLVE, 3'd0, 32'sd0, Q_MIN}, 1'b0, NO_RESULT},
        '{1'b1, CFG_RANGE, 47'd0, NO_WORD, 1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_SOLVE, 3'd0, 32'sd0, 64'sd12345}, 1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_LOAD, 3'd0, 32'sd0, 64'sd0}, 1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_LOAD, 3'd7, 32'sd0, 64'sd0}, 1'b0, NO_RESULT},
        '{1'b1, CFG_RANGE, 47'h1_0000_0000, NO_WORD, 1'b0, NO_RESULT},
        '{1'b1, CFG_DEGREE, 47'd1, NO_WORD, 1'b0, NO_RESULT},
        '{1'b1, CFG_TOLERANCE, 47'd4295, NO_WORD, 1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_SOLVE, 3'd0, 32'sd0, 64'sh0000_0000_4000_0000},
          1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_LOAD, 3'd1, 32'sd3, 64'sd0}, 1'b0, NO_RESULT},
        '{1'b0, CFG_DEGREE, '0, '{OP_SOLVE, 3'd0, 32'sd0, Q_ONE}, 1'b0, NO_RESULT}
    };

    polynomial_bisection_solver_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // fixed-point arithmetic of the solver
    function automatic q64_t sat_sum(q64_t a, q64_t b);
        q64_t s;
        s = a + b;
        if (!a[63] && !b[63] && s[63])
            return Q_MAX;
        if (a[63] && b[63] && !s[63])
            return Q_MIN;
        return s;
    endfunction

    function automatic q64_t sat_diff(q64_t a, q64_t b);
        q64_t r;
        r = a - b;
        if (!a[63] && b[63] && r[63])
            return Q_MAX;
        if (a[63] && !b[63] && !r[63])
            return Q_MIN;
        return r;
    endfunction

    function automatic logic [63:0] magnitude(q64_t v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic q64_t scaled_product(q64_t a, q64_t b, int unsigned shift);
        logic [127:0] prod;
        prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        prod = prod >> shift;
        if (a[63] ^ b[63])
        begin
            if (prod[127:64] != 0 || prod[63:0] >= 64'h8000_0000_0000_0000)
                return Q_MIN;
            return 64'd0 - prod[63:0];
        end
        if (prod[127:63] != 0)
            return Q_MAX;
        return prod[63:0];
    endfunction

    function automatic q64_t poly_value(q64_t x);
        q64_t acc;
        q64_t xp;
        acc = 0;
        xp  = Q_ONE;
        for (int i = 0; i <= int'(cur_degree); i++)
        begin
            acc = sat_sum(acc, scaled_product(coef_copy[i], xp, 0));
            xp  = scaled_product(xp, x, PBS_FRAC_BITS);
        end
        return acc;
    endfunction

    function automatic result_word_t solve_bisection(q64_t goal);
        q64_t         x;
        q64_t         lo_b;
        q64_t         hi_b;
        q64_t         last_x;
        q64_t         val;
        q64_t         resid;
        logic [63:0]  abs_resid;
        int           left;
        int           used;
        result_word_t r;
        hi_b = q64_t'({17'd0, cur_range});
        lo_b = -hi_b;
        x    = 0;
        left = int'(cur_attempts);
        used = 0;
        do
        begin
            last_x = x;
            val    = poly_value(x);
            if (val > goal)
            begin
                hi_b = x;
                x    = (x + lo_b) / 2;
            end
            else if (val < goal)
            begin
                lo_b = x;
                x    = (x + hi_b) / 2;
            end
            used++;
            if (left > 0)
                left--;
            resid     = sat_diff(val, goal);
            abs_resid = magnitude(resid);
        end
        while (abs_resid > cur_tolerance && left > 0);
        r.root          = last_x[47:0];
        r.attempts_used = used[15:0];
        r.found         = abs_resid < cur_tolerance;
        r.residual      = resid;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [31:0] rand_coef();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 20);
            4, 5:       return int'($urandom_range(0, 40)) - 20;
            6, 7:       return $urandom;
            8:          return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default:    return 0;
        endcase
    endfunction

    // mostly increasing polynomials so that the search can converge
    function automatic logic signed [31:0] rising_coef(int power);
        if (power == 0)
            return int'($urandom_range(0, 2000000)) - 1000000;
        if (power % 2 == 1)
            return $urandom_range(1, 9);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
    endfunction

    function automatic q64_t point_in_range();
        logic [63:0] u;
        if (cur_range == 0)
            return 0;
        u = rand64() % (2 * {17'd0, cur_range} + 1);
        return q64_t'(u) - q64_t'({17'd0, cur_range});
    endfunction

    function automatic in_word_t load_word(logic [2:0] idx, logic signed [31:0] value);
        in_word_t w;
        w.operation  = OP_LOAD;
        w.coef_index = idx;
        w.coef_value = value;
        w.target     = rand64();
        return w;
    endfunction

    function automatic in_word_t solve_word(q64_t goal);
        in_word_t w;
        w.operation  = OP_SOLVE;
        w.coef_index = 3'($urandom_range(0, 7));
        w.coef_value = $urandom;
        w.target     = goal;
        return w;
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEGREE:    cur_degree    = value[2:0];
            CFG_RANGE:     cur_range     = value[46:0];
            CFG_ATTEMPTS:  cur_attempts  = value[15:0];
            CFG_TOLERANCE: cur_tolerance = value[32:0];
            default: ;
        endcase
        cycle_budget += 8;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cycle_budget += 2 * SETTLE_CYCLES;
    endtask

    task automatic maybe_pause();
        int n;
        if (!quiet)
        begin
            if ($urandom_range(0, 99) < 20)
            begin
                n = $urandom_range(1, 9);
                start <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if ($urandom_range(0, 63) == 0)
                wait_idle();
        end
    endtask

    task automatic issue(in_word_t w, bit has_want = 1'b0, result_word_t want = '0);
        longint tries;
        start <= 1'b1;
        cmd   <= w;
        cycle_budget += 64;
        do
            @(posedge clk);
        while (busy);
        if (w.operation == OP_LOAD)
            coef_copy[w.coef_index] = w.coef_value;
        else
        begin
            tries = (cur_attempts == 0) ? 1 : cur_attempts;
            cycle_budget += 3 * tries * (14 * cur_degree + 10) + 64;
            pending_results.push_back(has_want ? want : solve_bisection(w.target));
        end
    endtask

    task automatic configure(int phase);
        logic [63:0] r;
        int          pick;
        write_reg(CFG_DEGREE, CFG_DATA_W'((phase == 1) ? 7 : (phase == 2) ? 0
                                                            : $urandom_range(0, 7)));

        r    = rand64();
        pick = $urandom_range(0, 3);
        if (phase == 3)
            write_reg(CFG_RANGE, 47'd0);
        else if (phase == 4)
            write_reg(CFG_RANGE, 47'h7fff_ffff_ffff);
        else if (pick == 0)
            write_reg(CFG_RANGE, 47'h1_0000_0000);
        else if (pick == 1)
            write_reg(CFG_RANGE, 47'd1 << $urandom_range(24, 40));
        else if (pick == 2)
            write_reg(CFG_RANGE, r[46:0]);
        else
            write_reg(CFG_RANGE, CFG_DATA_W'($urandom_range(0, 1 << 20)));

        pick = $urandom_range(0, 9);
        if (phase == 5)
            write_reg(CFG_ATTEMPTS, 47'd0);
        else if (phase == 6)
            write_reg(CFG_ATTEMPTS, 47'd1);
        else if (pick < 6)
            write_reg(CFG_ATTEMPTS, CFG_DATA_W'($urandom_range(1, 24)));
        else if (pick < 9)
            write_reg(CFG_ATTEMPTS, CFG_DATA_W'($urandom_range(25, 48)));
        else
            write_reg(CFG_ATTEMPTS, 47'd64);

        r    = rand64();
        pick = $urandom_range(0, 3);
        if (phase == 7)
            write_reg(CFG_TOLERANCE, 47'd0);
        else if (phase == 8)
            write_reg(CFG_TOLERANCE, 47'h1_0000_0000);
        else if (phase == 9)
            write_reg(CFG_TOLERANCE, 47'h1_ffff_ffff);
        else if (pick < 2)
            write_reg(CFG_TOLERANCE, CFG_DATA_W'($urandom_range(0, 100000)));
        else if (pick == 2)
            write_reg(CFG_TOLERANCE, 47'd4295);
        else
            write_reg(CFG_TOLERANCE, CFG_DATA_W'(r[32:0]));
    endtask

    task automatic run_phase(int phase);
        int       issued;
        int       pick;
        q64_t     goal;
        in_word_t w;
        configure(phase);
        issued = 0;
        while (issued < PHASE_WORDS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                // full coefficient set, then a few solves, most aimed near a point in range
                for (int i = 0; i <= int'(cur_degree); i++)
                begin
                    maybe_pause();
                    issue(load_word(3'(i), ($urandom_range(0, 6) == 0) ? rand_coef()
                                                                       : rising_coef(i)));
                    issued++;
                end
                repeat ($urandom_range(1, 3))
                begin
                    if ($urandom_range(0, 4) == 0)
                        goal = rand64();
                    else
                        goal = sat_sum(poly_value(point_in_range()),
                                       q64_t'(int'($urandom_range(0, 20000)) - 10000));
                    maybe_pause();
                    issue(solve_word(goal));
                    issued++;
                end
            end
            else if (pick < 9)
            begin
                w.operation  = op_t'($urandom_range(0, 1));
                w.coef_index = 3'($urandom_range(0, 7));
                w.coef_value = $urandom;
                w.target     = rand64();
                maybe_pause();
                issue(w);
                issued++;
            end
            else
            begin
                // partial reload, then solve for an arbitrary target
                repeat ($urandom_range(1, 3))
                begin
                    maybe_pause();
                    issue(load_word(3'($urandom_range(0, 7)), rand_coef()));
                    issued++;
                end
                maybe_pause();
                issue(solve_word(rand64()));
                issued++;
            end
        end
        wait_idle();
    endtask

    always @(posedge clk)
    begin : result_check
        result_word_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word: root=%h attempts=%0d found=%b residual=%h",
                             result.root, result.attempts_used, result.found, result.residual);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.root !== want.root ||
                    result.attempts_used !== want.attempts_used ||
                    result.found !== want.found ||
                    result.residual !== want.residual)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result mismatch: expected root=%h attempts=%0d found=%b ",
                                  "residual=%h, got root=%h attempts=%0d found=%b residual=%h"},
                                 want.root, want.attempts_used, want.found, want.residual,
                                 result.root, result.attempts_used, result.found,
                                 result.residual);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > cycle_budget)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_DEGREE;
        cfg_data  = '0;

        // register and store values after reset
        cur_degree    = 3'd0;
        cur_range     = 47'h1_0000_0000;
        cur_attempts  = 16'd64;
        cur_tolerance = 33'd4295;
        for (int i = 0; i <= PBS_MAX_DEGREE; i++)
            coef_copy[i] = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].is_write)
            begin
                wait_idle();
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end
            else
            begin
                maybe_pause();
                issue(plan[i].word, plan[i].checked, plan[i].want);
            end
        end
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            quiet = (p >= PHASES - QUIET_PHASES);
            run_phase(p);
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
